[design/assert_macros.svh]
// Assertion helpers shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define WSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("wsd assertion failed");

// When ante holds, cons must hold on the next clock edge.
`define WSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsd assertion failed");

`endif

[design/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

   localparam int LEN_W        = 63;
   localparam int RESULT_DEPTH = 4;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] KEY_LAST   = 3'd3;

   typedef enum logic [7:0] {
      PH_HDR0    = 8'b0000_0001,
      PH_HDR1    = 8'b0000_0010,
      PH_EXT16   = 8'b0000_0100,
      PH_EXT64   = 8'b0000_1000,
      PH_KEY     = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_SKIP    = 8'b0100_0000,
      PH_CLOSED  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data_byte;
      logic [3:0]       frame_opcode;
      logic [2:0]       reserved_bits;
      logic             final_flag;
      logic [LEN_W-1:0] frame_length;
      logic             closing;
      logic             last;
   } result_type;

   // Results produced by one accepted request, slot 0 first.
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

`default_nettype wire

[design/wsd_parser.sv]
// ----------------------------------------------------------------------------
// wsd_parser
// Per-byte header/payload state machine; produces up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsd_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        link_byte,
   output wsd_pkg::push_type      push
);

   localparam int LW = wsd_pkg::LEN_W;

   wsd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          in_msg_ff, in_msg_in;
   logic          fin_ff, fin_in;
   logic [3:0]    op_ff, op_in;
   logic [2:0]    rsv_ff, rsv_in;
   logic          masked_ff, masked_in;
   logic [31:0]   key_ff, key_in;
   logic [LW-1:0] len_ff, len_in;
   logic [1:0]    off_ff, off_in;

   logic          length_done, hdr_done, start, frame_end;
   logic          emit_a, emit_end, closes;
   logic [7:0]    key_byte;
   wsd_pkg::result_type res_a, res_end;

   always_comb begin
      unique case (off_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      in_msg_in   = in_msg_ff;
      fin_in      = fin_ff;
      op_in       = op_ff;
      rsv_in      = rsv_ff;
      masked_in   = masked_ff;
      key_in      = key_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      length_done = 1'b0;
      hdr_done    = 1'b0;
      start       = 1'b0;
      frame_end   = 1'b0;
      emit_a      = 1'b0;
      emit_end    = 1'b0;
      closes      = 1'b0;
      res_a       = '0;
      res_end     = '0;

      unique case (phase_ff)
         wsd_pkg::PH_HDR0: begin
            fin_in   = link_byte[7];
            rsv_in   = link_byte[6:4];
            op_in    = link_byte[3:0];
            phase_in = wsd_pkg::PH_HDR1;
         end
         wsd_pkg::PH_HDR1: begin
            masked_in = link_byte[7];
            cnt_in    = 3'd0;
            if (link_byte[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
               len_in   = '0;
               phase_in = wsd_pkg::PH_EXT16;
            end else if (link_byte[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
               len_in   = '0;
               phase_in = wsd_pkg::PH_EXT64;
            end else begin
               len_in      = {{(LW-7){1'b0}}, link_byte[6:0]};
               length_done = 1'b1;
            end
         end
         wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
            // big-endian; top bit of a 64-bit length falls off the end
            len_in = {len_ff[LW-9:0], link_byte};
            if (cnt_ff == ((phase_ff == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_LAST
                                                           : wsd_pkg::EXT64_LAST)) begin
               cnt_in      = 3'd0;
               length_done = 1'b1;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         wsd_pkg::PH_KEY: begin
            key_in = {key_ff[23:0], link_byte};
            if (cnt_ff >= wsd_pkg::KEY_LAST) begin
               cnt_in   = 3'd0;
               hdr_done = 1'b1;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            emit_a          = 1'b1;
            res_a.kind      = wsd_pkg::KIND_PAYLOAD;
            res_a.data_byte = masked_ff ? (link_byte ^ key_byte) : link_byte;
            off_in          = off_ff + 2'd1;
            // len_ff counts the bytes still due in this frame
            if (len_ff == LW'(1)) frame_end = 1'b1;
            else                  len_in    = len_ff - LW'(1);
         end
         wsd_pkg::PH_SKIP: begin
            if (len_ff == LW'(1)) phase_in = wsd_pkg::PH_HDR0;
            else                  len_in   = len_ff - LW'(1);
         end
         wsd_pkg::PH_CLOSED: begin
         end
         default: begin
         end
      endcase

      if (length_done) begin
         key_in = '0;
         if (masked_in) begin
            cnt_in   = 3'd0;
            phase_in = wsd_pkg::PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         res_a.frame_opcode  = op_ff;
         res_a.reserved_bits = rsv_ff;
         res_a.final_flag    = fin_ff;
         res_a.frame_length  = len_in;
         if (!in_msg_ff) begin
            emit_a     = 1'b1;
            res_a.kind = wsd_pkg::KIND_HEADER;
            start      = 1'b1;
         end else if (op_ff == wsd_pkg::OP_CONT) begin
            start = 1'b1;
         end else if (op_ff == wsd_pkg::OP_PING || op_ff == wsd_pkg::OP_PONG) begin
            off_in   = 2'd0;
            phase_in = (len_in == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_SKIP;
         end else begin
            emit_a     = 1'b1;
            res_a.kind = wsd_pkg::KIND_ERROR;
            in_msg_in  = 1'b0;
            phase_in   = wsd_pkg::PH_HDR0;
         end
      end

      if (start) begin
         off_in    = 2'd0;
         in_msg_in = 1'b1;
         if (len_in == '0) frame_end = 1'b1;
         else              phase_in  = wsd_pkg::PH_PAYLOAD;
      end

      if (frame_end) begin
         if (fin_ff) begin
            closes          = (op_ff == wsd_pkg::OP_CLOSE);
            emit_end        = 1'b1;
            res_end.kind    = wsd_pkg::KIND_END;
            res_end.closing = closes;
            in_msg_in       = 1'b0;
            phase_in        = closes ? wsd_pkg::PH_CLOSED : wsd_pkg::PH_HDR0;
         end else begin
            in_msg_in = 1'b1;
            phase_in  = wsd_pkg::PH_HDR0;
         end
      end
   end

   always_comb begin
      push.count   = accept ? ({1'b0, emit_a} + {1'b0, emit_end}) : 2'd0;
      push.r0      = emit_a ? res_a : res_end;
      push.r0.last = !(emit_a && emit_end);
      push.r1      = res_end;
      push.r1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsd_pkg::PH_HDR0;
         cnt_ff    <= '0;
         in_msg_ff <= 1'b0;
         fin_ff    <= 1'b0;
         op_ff     <= '0;
         rsv_ff    <= '0;
         masked_ff <= 1'b0;
         key_ff    <= '0;
         len_ff    <= '0;
         off_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         in_msg_ff <= in_msg_in;
         fin_ff    <= fin_in;
         op_ff     <= op_in;
         rsv_ff    <= rsv_in;
         masked_ff <= masked_in;
         key_ff    <= key_in;
         len_ff    <= len_in;
         off_ff    <= off_in;
      end
   end

   `WSD_ASSERT_NEXT(a_closed_sticky, clock, reset,
                    phase_ff == wsd_pkg::PH_CLOSED, phase_ff == wsd_pkg::PH_CLOSED)
   `WSD_ASSERT(a_pair_ends_with_end, clock, reset,
               push.count != 2'd2 || push.r1.kind == wsd_pkg::KIND_END)
   `WSD_ASSERT(a_closed_silent, clock, reset,
               phase_ff != wsd_pkg::PH_CLOSED || push.count == 2'd0)

endmodule

`default_nettype wire

[design/wsd_result_queue.sv]
// ----------------------------------------------------------------------------
// wsd_result_queue
// Small result queue: takes up to two results per cycle, gives out one per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsd_result_queue #(
   parameter int DEPTH = wsd_pkg::RESULT_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wsd_pkg::push_type    push,
   output logic                      full2,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output wsd_pkg::result_type       out_result
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wsd_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign pop        = out_valid && !out_stall;
   assign out_valid  = (count_ff != '0);
   assign out_result = mem_ff[rd_ptr_ff];
   // room for two results is needed before a request is taken
   assign full2      = (count_ff > CNT_W'(DEPTH - 2));

   always_comb begin
      wr_ptr_nx = ptr_inc(wr_ptr_ff);
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ptr_ff] <= push.r0;
      if (push.count == 2'd2) mem_ff[wr_ptr_nx] <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `WSD_ASSERT(a_no_overfill, clock, reset, count_ff <= CNT_W'(DEPTH))
   `WSD_ASSERT(a_push_has_room, clock, reset,
               push.count == 2'd0 || count_ff <= CNT_W'(DEPTH - 2))

endmodule

`default_nettype wire

[design/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser, one link byte per request.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while req_stall is low. Each byte updates
// the header/payload state machine in the cycle it is taken, and its results
// (none, one, or two when a message end coincides with a header or a frame's
// last payload byte) land in a DEPTH-entry result queue in the cycle after. A
// request is taken whenever the queue has room for two results, so with the
// result side draining one per cycle the block sustains one byte per cycle;
// the queue's single read port limits output to one result per cycle. After a
// final close frame all further bytes are taken and dropped until reset.
`default_nettype none

module websocket_frame_deframer #(
   parameter int RESULT_DEPTH = wsd_pkg::RESULT_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_link_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_data_byte,
   output logic [3:0]                      rsp_frame_opcode,
   output logic [2:0]                      rsp_reserved_bits,
   output logic                            rsp_final_flag,
   output logic [wsd_pkg::LEN_W-1:0]       rsp_frame_length,
   output logic                            rsp_closing,
   output logic                            rsp_last
);

   wsd_pkg::push_type   push;
   wsd_pkg::result_type head;
   logic                full2;
   logic                accept;

   assign req_stall = full2;
   assign accept    = req_valid && !req_stall;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .link_byte (req_link_byte),
      .push      (push)
   );

   wsd_result_queue #(
      .DEPTH (RESULT_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full2      (full2),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (head)
   );

   assign rsp_kind          = head.kind;
   assign rsp_data_byte     = head.data_byte;
   assign rsp_frame_opcode  = head.frame_opcode;
   assign rsp_reserved_bits = head.reserved_bits;
   assign rsp_final_flag    = head.final_flag;
   assign rsp_frame_length  = head.frame_length;
   assign rsp_closing       = head.closing;
   assign rsp_last          = head.last;

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for websocket_frame_deframer. Frames are built and sent
// one link byte per request. An in-bench parser of the same protocol predicts
// each header, payload byte, message end and error, and every result is
// checked in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int FORM_SHORT = 0;
   localparam int FORM_EXT16 = 1;
   localparam int FORM_EXT64 = 2;

   localparam int STALL_NONE   = 0;
   localparam int STALL_LIGHT  = 1;
   localparam int STALL_TOGGLE = 2;
   localparam int STALL_HEAVY  = 3;

   localparam int RANDOM_BYTES = 500;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int SETTLE_CYCLES = 12;

   localparam int LW = wsd_pkg::LEN_W;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_link_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [1:0]       rsp_kind;
   logic [7:0]       rsp_data_byte;
   logic [3:0]       rsp_frame_opcode;
   logic [2:0]       rsp_reserved_bits;
   logic             rsp_final_flag;
   logic [LW-1:0]    rsp_frame_length;
   logic             rsp_closing;
   logic             rsp_last;

   websocket_frame_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_link_byte     (req_link_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_reserved_bits (rsp_reserved_bits),
      .rsp_final_flag    (rsp_final_flag),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_closing       (rsp_closing),
      .rsp_last          (rsp_last)
   );

   // parser state mirrored by the bench
   wsd_pkg::phase_type df_phase = wsd_pkg::PH_HDR0;
   logic [2:0]       df_count = '0;
   logic             df_in_msg = 1'b0;
   logic             df_fin = 1'b0;
   logic [3:0]       df_op = '0;
   logic [2:0]       df_rsv = '0;
   logic             df_masked = 1'b0;
   logic [31:0]      df_key = '0;
   logic [LW-1:0]    df_len = '0;
   logic [LW-1:0]    df_offset = '0;

   wsd_pkg::result_type byte_results [$];
   wsd_pkg::result_type results_due [$];

   int mismatches = 0;
   int bytes_sent = 0;
   int burst_left = 0;
   bit guard_close = 1'b1;   // keep the stream open until the close test

   int stall_mode = STALL_NONE;
   int stall_run = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // prediction
   // -------------------------------------------------------------------------
   function automatic void note_result(logic [1:0] kind, logic [7:0] data,
                                       logic [3:0] op, logic [2:0] rsv,
                                       logic fin, logic [LW-1:0] len,
                                       logic closing);
      wsd_pkg::result_type r;
      r.kind          = kind;
      r.data_byte     = data;
      r.frame_opcode  = op;
      r.reserved_bits = rsv;
      r.final_flag    = fin;
      r.frame_length  = len;
      r.closing       = closing;
      r.last          = 1'b0;
      if (byte_results.size() < 2) byte_results.push_back(r);
   endfunction

   function automatic void end_frame();
      logic closed;
      if (df_fin) begin
         closed = (df_op == wsd_pkg::OP_CLOSE);
         note_result(wsd_pkg::KIND_END, 8'h00, 4'h0, 3'h0, 1'b0, '0, closed);
         df_in_msg = 1'b0;
         df_phase = closed ? wsd_pkg::PH_CLOSED : wsd_pkg::PH_HDR0;
      end else begin
         df_in_msg = 1'b1;
         df_phase = wsd_pkg::PH_HDR0;
      end
   endfunction

   function automatic void open_frame();
      df_offset = '0;
      df_in_msg = 1'b1;
      if (df_len == '0) end_frame();
      else df_phase = wsd_pkg::PH_PAYLOAD;
   endfunction

   function automatic void close_header();
      if (!df_in_msg) begin
         note_result(wsd_pkg::KIND_HEADER, 8'h00, df_op, df_rsv, df_fin, df_len, 1'b0);
         open_frame();
      end else if (df_op == wsd_pkg::OP_CONT) begin
         open_frame();
      end else if (df_op == wsd_pkg::OP_PING || df_op == wsd_pkg::OP_PONG) begin
         // control frame inside a message: payload dropped silently
         df_offset = '0;
         df_phase = (df_len == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_SKIP;
      end else begin
         note_result(wsd_pkg::KIND_ERROR, 8'h00, df_op, df_rsv, df_fin, df_len, 1'b0);
         df_in_msg = 1'b0;
         df_phase = wsd_pkg::PH_HDR0;
      end
   endfunction

   function automatic void length_done();
      df_key = '0;
      if (df_masked) begin
         df_count = '0;
         df_phase = wsd_pkg::PH_KEY;
      end else begin
         close_header();
      end
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      logic [7:0] d;
      logic [1:0] key_idx;
      logic       ext_done;
      wsd_pkg::result_type r;
      byte_results.delete();
      case (df_phase)
         wsd_pkg::PH_HDR1: begin
            df_masked = b[7];
            df_len = {{(LW-7){1'b0}}, b[6:0]};
            df_count = '0;
            if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
               df_len = '0;
               df_phase = wsd_pkg::PH_EXT16;
            end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
               df_len = '0;
               df_phase = wsd_pkg::PH_EXT64;
            end else begin
               length_done();
            end
         end
         wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
            // shifting into 63 bits drops the top bit of a 64-bit length
            df_len = {df_len[LW-9:0], b};
            ext_done = (df_count == ((df_phase == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_LAST
                                                                     : wsd_pkg::EXT64_LAST));
            if (ext_done) begin
               df_count = '0;
               length_done();
            end else begin
               df_count = df_count + 3'd1;
            end
         end
         wsd_pkg::PH_KEY: begin
            df_key = {df_key[23:0], b};
            if (df_count >= wsd_pkg::KEY_LAST) begin
               df_count = '0;
               close_header();
            end else begin
               df_count = df_count + 3'd1;
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            d = b;
            if (df_masked) begin
               key_idx = 2'd3 - df_offset[1:0];
               d = d ^ df_key[key_idx*8 +: 8];
            end
            note_result(wsd_pkg::KIND_PAYLOAD, d, 4'h0, 3'h0, 1'b0, '0, 1'b0);
            df_offset = df_offset + 1'b1;
            if (df_offset >= df_len) end_frame();
         end
         wsd_pkg::PH_SKIP: begin
            df_offset = df_offset + 1'b1;
            if (df_offset >= df_len) df_phase = wsd_pkg::PH_HDR0;
         end
         wsd_pkg::PH_CLOSED: begin
         end
         default: begin
            df_fin = b[7];
            df_rsv = b[6:4];
            df_op = b[3:0];
            df_phase = wsd_pkg::PH_HDR1;
         end
      endcase
      if (byte_results.size() > 0) begin
         r = byte_results.pop_back();
         r.last = 1'b1;
         byte_results.push_back(r);
      end
      foreach (byte_results[i]) results_due.push_back(byte_results[i]);
   endfunction

   // -------------------------------------------------------------------------
   // checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
   endtask

   always @(posedge clock) begin : check_results
      wsd_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            report_mismatch("result with nothing due, kind", 64'(rsp_kind), '0);
         end else begin
            want = results_due.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 64'(rsp_kind), 64'(want.kind));
            if (rsp_data_byte !== want.data_byte)
               report_mismatch("data_byte", 64'(rsp_data_byte), 64'(want.data_byte));
            if (rsp_frame_opcode !== want.frame_opcode)
               report_mismatch("frame_opcode", 64'(rsp_frame_opcode),
                               64'(want.frame_opcode));
            if (rsp_reserved_bits !== want.reserved_bits)
               report_mismatch("reserved_bits", 64'(rsp_reserved_bits),
                               64'(want.reserved_bits));
            if (rsp_final_flag !== want.final_flag)
               report_mismatch("final_flag", 64'(rsp_final_flag), 64'(want.final_flag));
            if (rsp_frame_length !== want.frame_length)
               report_mismatch("frame_length", 64'(rsp_frame_length),
                               64'(want.frame_length));
            if (rsp_closing !== want.closing)
               report_mismatch("closing", 64'(rsp_closing), 64'(want.closing));
            if (rsp_last !== want.last)
               report_mismatch("last", 64'(rsp_last), 64'(want.last));
         end
      end
   end

   // receiver backpressure; a new mode is drawn whenever stall_run reaches zero
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= $urandom_range(STALL_NONE, STALL_HEAVY);
         stall_run <= $urandom_range(16, 96);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_TOGGLE: rsp_stall <= stall_run[2];
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 99) < 80);
         default:      rsp_stall <= 1'b0;
      endcase
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (guard_close && df_phase == wsd_pkg::PH_HDR0 && !df_in_msg &&
          b[3:0] == wsd_pkg::OP_CLOSE)
         b[7] = 1'b0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_link_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      deframe_byte(b);
   endtask

   // request side goes quiet, then everything due must arrive
   task automatic wait_drained();
      int n;
      @(negedge clock);
      req_valid <= 1'b0;
      for (n = 0; n < DRAIN_LIMIT && results_due.size() != 0; n++) @(posedge clock);
      if (results_due.size() != 0) begin
         report_mismatch("results never arrived, count", 64'(results_due.size()), '0);
         results_due.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      if (r < 85) return $urandom_range(1, 12);
      if (r < 97) return $urandom_range(13, 125);
      return $urandom_range(126, 300);
   endfunction

   function automatic int pick_form();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return FORM_SHORT;
      if (r < 88) return FORM_EXT16;
      return FORM_EXT64;
   endfunction

   task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic masked, input int unsigned len, input int form);
      logic [31:0] key;
      logic        top_bit;
      int          f;
      int unsigned i;
      f = form;
      if (f == FORM_SHORT && len >= 126) f = FORM_EXT16;
      key = $urandom;
      top_bit = 1'($urandom_range(0, 1));
      send_byte({fin, rsv, op});
      case (f)
         FORM_SHORT: send_byte({masked, len[6:0]});
         FORM_EXT16: begin
            send_byte({masked, wsd_pkg::LEN_CODE_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({masked, wsd_pkg::LEN_CODE_EXT64});
            send_byte({top_bit, 7'd0});
            repeat (5) send_byte(8'h00);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
      endcase
      if (masked)
         for (i = 0; i < 4; i++) send_byte(key[31-8*i -: 8]);
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   // random byte that keeps any length it lands in small
   function automatic logic [7:0] tame_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (df_phase == wsd_pkg::PH_EXT16 && df_count == 0) b = 8'h00;
      if (df_phase == wsd_pkg::PH_EXT64 && df_count < wsd_pkg::EXT64_LAST) b = 8'h00;
      return b;
   endfunction

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) send_byte(tame_byte());
      while (df_phase != wsd_pkg::PH_HDR0) send_byte(tame_byte());
   endtask

   task automatic send_message();
      int unsigned pieces;
      int unsigned k;
      logic [3:0]  first_op;
      logic [3:0]  odd_op;
      if (df_in_msg)
         send_frame(1'b1, 3'($urandom_range(0, 7)), wsd_pkg::OP_CONT,
                    1'($urandom_range(0, 1)), pick_length(), pick_form());
      pieces = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
      first_op = 4'($urandom_range(0, 15));
      if (first_op == wsd_pkg::OP_CLOSE && pieces == 1) pieces = 2;
      for (k = 0; k < pieces; k++) begin
         if (k > 0 && $urandom_range(0, 99) < 20)
            send_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       ($urandom_range(0, 1) == 1) ? wsd_pkg::OP_PING : wsd_pkg::OP_PONG,
                       1'($urandom_range(0, 1)), $urandom_range(0, 5), pick_form());
         if (k > 0 && $urandom_range(0, 99) < 6) begin
            // wrong opcode where a continuation is due aborts the message
            do odd_op = 4'($urandom_range(1, 15));
            while (odd_op == wsd_pkg::OP_PING || odd_op == wsd_pkg::OP_PONG);
            send_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), odd_op,
                       1'($urandom_range(0, 1)), 0, pick_form());
            return;
         end
         send_frame(k == pieces - 1, 3'($urandom_range(0, 7)),
                    (k == 0) ? first_op : wsd_pkg::OP_CONT,
                    $urandom_range(0, 3) != 0, pick_length(), pick_form());
      end
   endtask

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   task automatic test_basic_frames();
      send_byte(8'h81);   // final text, unmasked, one byte
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(8'h82);   // final binary, masked, empty: header and end together
      send_byte(8'h80);
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      wait_drained();
   endtask

   task automatic test_fragments();
      send_byte(8'h7F);   // non-final, all rsv bits, 16-bit length of 2
      send_byte(8'h7E);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h8A);   // empty pong between fragments
      send_byte(8'h00);
      send_byte(8'h09);   // ping with one byte, skipped
      send_byte(8'h01);
      send_byte(8'h5A);
      send_byte(8'h80);   // masked final continuation
      send_byte(8'h81);
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      send_byte(8'h3C);
      wait_drained();
   endtask

   task automatic test_ext64_and_error();
      send_byte(8'h08);   // non-final close, 64-bit length with only the top bit set
      send_byte(8'h7F);
      send_byte(8'h80);
      repeat (7) send_byte(8'h00);
      send_byte(8'h80);   // continuation ends it, must not close
      send_byte(8'h00);
      send_byte(8'h01);   // non-final text, then a new frame with opcode 3: error
      send_byte(8'h00);
      send_byte(8'h03);
      send_byte(8'h00);
      wait_drained();
   endtask

   task automatic test_random_stream();
      int stop_at;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 99) < 8) send_noise();
         else send_message();
      end
      wait_drained();
   endtask

   task automatic test_close_frame();
      // finish any open message so the close frame starts a new one
      if (df_in_msg) send_frame(1'b1, 3'd0, wsd_pkg::OP_CONT, 1'b0, 0, FORM_SHORT);
      guard_close = 1'b0;
      send_byte(8'h88);   // final close, empty
      send_byte(8'h00);
      send_byte(8'h81);   // ignored once closed
      send_byte(8'h01);
      send_byte(8'hAA);
      send_byte(8'hFF);
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_frames();
      test_fragments();
      test_ext64_and_error();
      test_random_stream();
      test_close_frame();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[websocket_frame_deframer.f]
+incdir+design
design/wsd_pkg.sv
design/wsd_parser.sv
design/wsd_result_queue.sv
design/websocket_frame_deframer.sv
tb/tb.sv
